FILE: src/first_fit_pool_allocator_core_defines.svh
// assertion macros for the pool allocator core
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FFPA_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
`define FFPA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define FFPA_ASSERT_SAME(label, pre, post)
`define FFPA_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: src/ffpa_pkg.sv
package ffpa_pkg;

   localparam int HEADER_BYTES_DEF   = 24;
   localparam int MAX_BLOCKS_DEF     = 64;
   localparam int POOL_MAX_BYTES_DEF = 65536;
   localparam logic [16:0] POOL_RESET = 17'd65536;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REINIT  = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] request_size;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
      logic [15:0] block_bytes;
   } rsp_type;

   typedef struct packed {
      logic [15:0] block_start;
      logic [15:0] block_length;
      logic        block_is_free;
   } entry_type;

endpackage

FILE: src/ffpa_table.sv
module ffpa_table #(
   parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF,
   localparam int IW = $clog2(MAX_BLOCKS)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  ffpa_pkg::entry_type wr_data,
   input  logic [IW-1:0]       rd_addr,
   output ffpa_pkg::entry_type rd_data
);

   ffpa_pkg::entry_type mem [MAX_BLOCKS];
   ffpa_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/first_fit_pool_allocator_core.sv
// reinit and release answer from the decode state; allocate and free
// walk the block table one entry per cycle, a split first moves the entries above
// the hit up by one, and a free adds a merge pass over the table
// one command at a time, the next start is taken in the strobe cycle; no result stall
// reset: synchronous, the init state writes the single free block, busy high
`include "first_fit_pool_allocator_core_defines.svh"

module first_fit_pool_allocator_core #(
   parameter int HEADER_BYTES   = ffpa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS     = ffpa_pkg::MAX_BLOCKS_DEF,
   parameter int POOL_MAX_BYTES = ffpa_pkg::POOL_MAX_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffpa_pkg::req_type req_word,
   output logic              rsp_valid,
   output ffpa_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [16:0]       csr_data
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [16:0] HDR = 17'(HEADER_BYTES);
   localparam logic [16:0] POOL_CAP =
      (POOL_MAX_BYTES < 65536) ? 17'(POOL_MAX_BYTES) : 17'd65536;
   localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

   typedef enum logic [7:0] {
      S_INIT     = 8'b00000001,
      S_IDLE     = 8'b00000010,
      S_DECODE   = 8'b00000100,
      S_SCAN     = 8'b00001000,
      S_SHIFT    = 8'b00010000,
      S_SPLIT_HI = 8'b00100000,
      S_SPLIT_LO = 8'b01000000,
      S_MERGE    = 8'b10000000
   } state_type;

   function automatic logic [15:0] first_len(input logic [16:0] pool);
      logic [16:0] eff;
      eff = (pool > POOL_CAP) ? POOL_CAP : pool;
      return (eff > HDR) ? 16'(eff - HDR) : 16'd0;
   endfunction

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   ffpa_pkg::req_type   cmd_ff, cmd_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [IW-1:0]       chk_idx_ff, chk_idx_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   ffpa_pkg::entry_type hit_ff, hit_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                sh_vld_ff, sh_vld_in;
   logic [IW-1:0]       sh_wa_ff, sh_wa_in;
   logic [IW-1:0]       w_ff, w_in;
   ffpa_pkg::entry_type pend_ff, pend_in;
   logic                merge_end_ff, merge_end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ffpa_pkg::rsp_type   rsp_ff, rsp_in;
   logic [16:0]         pool_bytes_ff;

   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   ffpa_pkg::entry_type wr_data;
   logic [IW-1:0]       rd_addr;
   ffpa_pkg::entry_type rd_data;

   ffpa_table #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      logic                issue;
      logic                last;
      logic                fit;
      logic                split;
      logic                match;
      ffpa_pkg::entry_type cur;
      logic [15:0]         len0;

      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      ptr_in       = ptr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_idx_in   = hit_idx_ff;
      hit_in       = hit_ff;
      k_in         = k_ff;
      sh_vld_in    = 1'b0;
      sh_wa_in     = sh_wa_ff;
      w_in         = w_ff;
      pend_in      = pend_ff;
      merge_end_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = rd_data;
      rd_addr      = ptr_ff[IW-1:0];
      cur          = rd_data;
      issue        = ptr_ff < count_ff;
      last         = {1'b0, chk_idx_ff} == (count_ff - CW'(1));
      fit          = cur.block_is_free && (cur.block_length >= cmd_ff.request_size);
      split        = ({1'b0, cur.block_length} > ({1'b0, cmd_ff.request_size} + HDR))
                     && (count_ff < FULL);
      match        = ({1'b0, cur.block_start} + HDR) == {1'b0, cmd_ff.address};
      len0         = first_len(pool_bytes_ff);

      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{block_start: 16'd0, block_length: first_len(ffpa_pkg::POOL_RESET),
                         block_is_free: 1'b1};
            count_in = CW'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_word;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            ptr_in = '0;
            w_in   = '0;
            unique case (cmd_ff.command)
               ffpa_pkg::CMD_REINIT: begin
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  wr_data      = '{block_start: 16'd0, block_length: len0,
                                   block_is_free: 1'b1};
                  count_in     = CW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ffpa_pkg::ST_OK, payload_offset: 16'd0,
                                   block_bytes: len0};
                  state_in     = S_IDLE;
               end
               ffpa_pkg::CMD_RELEASE: begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ffpa_pkg::ST_OK, payload_offset: 16'd0,
                                   block_bytes: 16'd0};
                  state_in     = S_IDLE;
               end
               default: begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: (cmd_ff.command == ffpa_pkg::CMD_ALLOC) ?
                                      ffpa_pkg::ST_NO_FIT : ffpa_pkg::ST_BAD_ADDR,
                                      payload_offset: 16'd0, block_bytes: 16'd0};
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_SCAN: begin
            if (issue) begin
               ptr_in     = ptr_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[IW-1:0];
            end
            if (chk_vld_ff) begin
               hit_idx_in = chk_idx_ff;
               hit_in     = cur;
               if (cmd_ff.command == ffpa_pkg::CMD_ALLOC && fit) begin
                  chk_vld_in = 1'b0;
                  if (split) begin
                     k_in     = count_ff;
                     state_in = S_SHIFT;
                  end else begin
                     wr_en        = 1'b1;
                     wr_addr      = chk_idx_ff;
                     wr_data      = '{block_start: cur.block_start,
                                      block_length: cur.block_length, block_is_free: 1'b0};
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ffpa_pkg::ST_OK,
                                      payload_offset: cur.block_start + HDR[15:0],
                                      block_bytes: cur.block_length};
                     state_in     = S_IDLE;
                  end
               end else if (cmd_ff.command == ffpa_pkg::CMD_FREE && match) begin
                  wr_en      = 1'b1;
                  wr_addr    = chk_idx_ff;
                  wr_data    = '{block_start: cur.block_start,
                                 block_length: cur.block_length, block_is_free: 1'b1};
                  ptr_in     = '0;
                  chk_vld_in = 1'b0;
                  state_in   = S_MERGE;
               end else if (last) begin
                  chk_vld_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: (cmd_ff.command == ffpa_pkg::CMD_ALLOC) ?
                                   ffpa_pkg::ST_NO_FIT : ffpa_pkg::ST_BAD_ADDR,
                                   payload_offset: 16'd0, block_bytes: 16'd0};
                  state_in     = S_IDLE;
               end
            end
         end
         S_SHIFT: begin
            // move entries above the hit up by one, top first
            if (k_ff > ({1'b0, hit_idx_ff} + CW'(1))) begin
               rd_addr   = IW'(k_ff - CW'(1));
               sh_vld_in = 1'b1;
               sh_wa_in  = k_ff[IW-1:0];
               k_in      = k_ff - CW'(1);
            end else if (!sh_vld_ff) begin
               state_in = S_SPLIT_HI;
            end
            if (sh_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = sh_wa_ff;
               wr_data = rd_data;
            end
         end
         S_SPLIT_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hit_idx_ff + IW'(1);
            wr_data  = '{block_start: hit_ff.block_start + HDR[15:0] + cmd_ff.request_size,
                         block_length: hit_ff.block_length - cmd_ff.request_size - HDR[15:0],
                         block_is_free: 1'b1};
            state_in = S_SPLIT_LO;
         end
         S_SPLIT_LO: begin
            wr_en        = 1'b1;
            wr_addr      = hit_idx_ff;
            wr_data      = '{block_start: hit_ff.block_start,
                             block_length: cmd_ff.request_size, block_is_free: 1'b0};
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ffpa_pkg::ST_OK,
                             payload_offset: hit_ff.block_start + HDR[15:0],
                             block_bytes: cmd_ff.request_size};
            state_in     = S_IDLE;
         end
         S_MERGE: begin
            // compacting pass: runs of free blocks fold into the pending entry
            if (merge_end_ff) begin
               wr_en        = 1'b1;
               wr_addr      = w_ff;
               wr_data      = pend_ff;
               count_in     = CW'(w_ff) + CW'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ffpa_pkg::ST_OK, payload_offset: 16'd0,
                                block_bytes: hit_ff.block_length};
               state_in     = S_IDLE;
            end else begin
               if (issue) begin
                  ptr_in     = ptr_ff + CW'(1);
                  chk_vld_in = 1'b1;
                  chk_idx_in = ptr_ff[IW-1:0];
               end
               if (chk_vld_ff) begin
                  if (chk_idx_ff == '0) begin
                     pend_in = cur;
                  end else if (pend_ff.block_is_free && cur.block_is_free) begin
                     pend_in.block_length = pend_ff.block_length + HDR[15:0]
                                            + cur.block_length;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = w_ff;
                     wr_data = pend_ff;
                     w_in    = w_ff + IW'(1);
                     pend_in = cur;
                  end
                  if (last) begin
                     chk_vld_in   = 1'b0;
                     merge_end_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         count_ff      <= CW'(1);
         chk_vld_ff    <= 1'b0;
         sh_vld_ff     <= 1'b0;
         merge_end_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pool_bytes_ff <= ffpa_pkg::POOL_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         sh_vld_ff    <= sh_vld_in;
         merge_end_ff <= merge_end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            pool_bytes_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ptr_ff     <= ptr_in;
      chk_idx_ff <= chk_idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff     <= hit_in;
      k_ff       <= k_in;
      sh_wa_ff   <= sh_wa_in;
      w_ff       <= w_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `FFPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `FFPA_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff)
   `FFPA_ASSERT_SAME(a_split_room, state_ff == S_SPLIT_LO, count_ff < FULL)
   `FFPA_ASSERT_SAME(a_fail_zero, rsp_valid_ff && rsp_ff.status != ffpa_pkg::ST_OK,
                     rsp_ff.payload_offset == 16'd0)

endmodule
